// ===== rtl/core/smpl_pkg.sv =====
// Shared types and constants of the stick-to-motor PWM and lamp unit.
`default_nettype none
package smpl_pkg;

  // Operation codes of an input transaction
  localparam logic OP_REPORT = 1'b0;
  localparam logic OP_TICK   = 1'b1;

  // Lamp color codes
  localparam logic [1:0] LAMP_OFF   = 2'd0;
  localparam logic [1:0] LAMP_WHITE = 2'd1;
  localparam logic [1:0] LAMP_AMBER = 2'd2;

  localparam logic [8:0]         DEADZONE_RST = 9'd51;
  localparam logic signed [11:0] FULL_SCALE   = 12'sd510;
  localparam logic signed [11:0] STEER_CENTER = 12'sd1530;
  // floor(m * 257 / 80) == (m * STEER_MUL) >> STEER_SHIFT for m <= 2040
  localparam logic [21:0]        STEER_MUL    = 22'd3368551;
  localparam int                 STEER_SHIFT  = 20;
  localparam int                 QUEUE_DEPTH  = 2;

  typedef struct packed {
    logic              operation;
    logic signed [7:0] stick_x;
    logic signed [7:0] stick_y;
    logic              press_select;
    logic              press_triangle;
    logic              press_cross;
    logic              press_square;
    logic              press_circle;
    logic              press_start;
    logic              link_up;
  } in_item_t;

  typedef struct packed {
    logic        duty_write;
    logic [15:0] duty_forward;
    logic [15:0] duty_reverse;
    logic [12:0] duty_steer;
    logic [1:0]  lamp_left;
    logic [1:0]  lamp_right;
  } out_item_t;

  // Classified command between front and back
  typedef struct packed {
    logic               is_tick;
    logic               duty_write;
    logic signed [10:0] dx;
    logic signed [10:0] dy;
    logic [1:0]         lamp_left;
    logic [1:0]         lamp_right;
  } cmd_t;

  // Queue status seen by the front
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage
`default_nettype wire

// ===== rtl/core/stick_to_motor_pwm_and_lights_unit.sv =====
// Top level of the stick-to-motor PWM and lamp unit.
//
//   Channel   Ports                            Direction  Handshake
//   input     in_valid, in_ready, in_item      in         valid/ready
//   result    out_valid, out_ready, out_item   out        valid/ready
//   config    cfg_we, cfg_wdata                in         write enable, no wait
//
// One transaction per cycle sustained while out_ready stays high; a result leaves
// after its input passes the queue entry, dead zone stage and duty scaling stage.
// The steering multiply (11 x 22 bits) in the last stage sets the clock path.
// Synchronous active-low reset clears offsets, lamp flags, blink phase and all
// valid state, and loads the dead zone with 51. A stalled result holds in the
// output register; in_ready drops only once the two-entry queue fills.
`default_nettype none
module stick_to_motor_pwm_and_lights_unit (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_ready,
  input  smpl_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  wire                 out_ready,
  output smpl_pkg::out_item_t out_item,
  input  wire                 cfg_we,
  input  wire [8:0]           cfg_wdata
);
  import smpl_pkg::*;

  q_status_t q_status;
  logic      push;
  cmd_t      push_cmd;
  logic      q_valid;
  cmd_t      q_cmd;
  logic      q_pop;

  // Front: classify transactions, update calibration and lamp flags
  smpl_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .q_status (q_status),
    .push     (push),
    .push_cmd (push_cmd)
  );

  // Decouple front and back so each side stalls on its own
  smpl_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .q_status (q_status),
    .q_valid  (q_valid),
    .q_cmd    (q_cmd),
    .q_pop    (q_pop)
  );

  // Back: dead zone, clamp and duty scaling, holds the dead zone register
  smpl_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .q_valid   (q_valid),
    .q_cmd     (q_cmd),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule
`default_nettype wire

// ===== rtl/core/smpl_front.sv =====
// Front end: accept transactions, update calibration and lamp state, emit commands.
`default_nettype none
module smpl_front (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_valid,
  output logic                 in_ready,
  input  smpl_pkg::in_item_t   in_item,
  input  smpl_pkg::q_status_t  q_status,
  output logic                 push,
  output smpl_pkg::cmd_t       push_cmd
);
  import smpl_pkg::*;

  logic signed [9:0] off_x_r, off_x_nxt;
  logic signed [9:0] off_y_r, off_y_nxt;
  logic              hb_r, hb_nxt;
  logic              bl_r, bl_nxt;
  logic              br_r, br_nxt;
  logic              ph_r, ph_nxt;
  logic              accept;
  logic              is_report;
  logic              ph_show;
  logic signed [9:0] vx;
  logic signed [9:0] vy;

  function automatic logic [1:0] lamp_code(input logic blink, input logic phase,
                                           input logic beam);
    logic [1:0] c;
    if (blink && phase) c = LAMP_AMBER;
    else if (beam)      c = LAMP_WHITE;
    else                c = LAMP_OFF;
    return c;
  endfunction

  assign in_ready  = !q_status.full;
  assign accept    = in_valid && in_ready;
  assign push      = accept;
  assign is_report = (in_item.operation == OP_REPORT);
  // 4*(s+128)-510 reduces to 4*s+2
  assign vx = $signed({in_item.stick_x, 2'b10});
  assign vy = $signed({in_item.stick_y, 2'b10});

  always_comb begin
    off_x_nxt = off_x_r;
    off_y_nxt = off_y_r;
    hb_nxt    = hb_r;
    bl_nxt    = bl_r;
    br_nxt    = br_r;
    ph_nxt    = ph_r;
    if (accept && is_report) begin
      if (in_item.press_select) begin
        off_x_nxt = vx;
        off_y_nxt = vy;
      end
      if (in_item.press_triangle) begin
        hb_nxt = 1'b1;
        bl_nxt = 1'b0;
        br_nxt = 1'b0;
      end else if (in_item.press_cross) begin
        hb_nxt = 1'b0;
        bl_nxt = 1'b0;
        br_nxt = 1'b0;
      end else if (in_item.press_square) begin
        ph_nxt = 1'b1;
        br_nxt = 1'b0;
        bl_nxt = ~bl_r;
      end else if (in_item.press_circle) begin
        ph_nxt = 1'b1;
        bl_nxt = 1'b0;
        br_nxt = ~br_r;
      end else if (in_item.press_start) begin
        ph_nxt = 1'b1;
        bl_nxt = ~bl_r;
        br_nxt = ~br_r;
      end
    end else if (accept) begin
      // tick: show the current phase, then flip it
      ph_nxt = ~ph_r;
    end
  end

  assign ph_show = is_report ? ph_nxt : ph_r;

  always_comb begin
    push_cmd.is_tick    = !is_report;
    push_cmd.duty_write = is_report ? 1'b1 : !in_item.link_up;
    push_cmd.dx         = $signed({vx[9], vx}) - $signed({off_x_nxt[9], off_x_nxt});
    push_cmd.dy         = $signed({vy[9], vy}) - $signed({off_y_nxt[9], off_y_nxt});
    push_cmd.lamp_left  = lamp_code(bl_nxt, ph_show, hb_nxt);
    push_cmd.lamp_right = lamp_code(br_nxt, ph_show, hb_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      off_x_r <= '0;
      off_y_r <= '0;
      hb_r    <= 1'b0;
      bl_r    <= 1'b0;
      br_r    <= 1'b0;
      ph_r    <= 1'b0;
    end else begin
      off_x_r <= off_x_nxt;
      off_y_r <= off_y_nxt;
      hb_r    <= hb_nxt;
      bl_r    <= bl_nxt;
      br_r    <= br_nxt;
      ph_r    <= ph_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_turn_sets_phase: assert property (@(posedge clk) disable iff (!rst_n)
    accept && is_report && !in_item.press_triangle && !in_item.press_cross &&
    (in_item.press_square || in_item.press_circle || in_item.press_start) |=> ph_r)
    else $error("blinker press did not set the blink phase");
  a_tick_keeps_flags: assert property (@(posedge clk) disable iff (!rst_n)
    accept && !is_report |=> $stable(hb_r) && $stable(bl_r) && $stable(br_r))
    else $error("tick changed lamp flags");
  a_tick_flips_phase: assert property (@(posedge clk) disable iff (!rst_n)
    accept && !is_report |=> ph_r != $past(ph_r))
    else $error("tick did not flip the blink phase");
`endif

endmodule
`default_nettype wire

// ===== rtl/core/smpl_queue.sv =====
// Two-entry command queue between front and back.
`default_nettype none
module smpl_queue (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  push,
  input  smpl_pkg::cmd_t       push_cmd,
  output smpl_pkg::q_status_t  q_status,
  output logic                 q_valid,
  output smpl_pkg::cmd_t       q_cmd,
  input  wire                  q_pop
);
  import smpl_pkg::*;

  cmd_t       mem_r [QUEUE_DEPTH];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       do_push;
  logic       do_pop;

  assign q_status.full  = (cnt_r == 2'(QUEUE_DEPTH));
  assign q_status.empty = (cnt_r == 2'd0);
  assign q_valid        = !q_status.empty;
  assign q_cmd          = mem_r[rd_ptr_r];
  assign do_push        = push && !q_status.full;
  assign do_pop         = q_pop && q_valid;

  always_comb begin
    wr_ptr_nxt = do_push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push && !do_pop) cnt_nxt = cnt_r + 2'd1;
    else if (do_pop && !do_push) cnt_nxt = cnt_r - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push_cmd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 2'(QUEUE_DEPTH))
    else $error("queue count out of range");
  a_pop_only: assert property (@(posedge clk) disable iff (!rst_n)
    do_pop && !do_push |=> cnt_r == $past(cnt_r) - 2'd1)
    else $error("queue count did not drop on pop");
  a_ptr_track: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_ptr_r ^ rd_ptr_r) == cnt_r[0])
    else $error("queue pointers disagree with count");
`endif

endmodule
`default_nettype wire

// ===== rtl/core/smpl_back.sv =====
// Back end: dead zone and clamp stage, then duty scaling into the output register.
`default_nettype none
module smpl_back (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 cfg_we,
  input  wire [8:0]           cfg_wdata,
  input  wire                 q_valid,
  input  smpl_pkg::cmd_t      q_cmd,
  output logic                q_pop,
  output logic                out_valid,
  input  wire                 out_ready,
  output smpl_pkg::out_item_t out_item
);
  import smpl_pkg::*;

  logic [8:0]        deadzone_r;
  logic              a_valid_r, a_valid_nxt;
  logic              a_tick_r;
  logic              a_wr_r;
  logic signed [9:0] a_sx_r;
  logic signed [9:0] a_sy_r;
  logic [1:0]        a_ll_r;
  logic [1:0]        a_lr_r;
  logic              b_valid_r, b_valid_nxt;
  out_item_t         b_item_r, b_item_nxt;
  logic              b_ready;
  logic              a_ready;
  logic              a_move;
  logic [8:0]        mag_y;
  logic [16:0]       mul_y;
  logic signed [11:0] m_wide;
  logic [10:0]       m_steer;
  logic [32:0]       mul_s;

  function automatic logic signed [9:0] shape(input logic signed [10:0] d,
                                              input logic [8:0] r);
    logic signed [11:0] dd;
    logic signed [11:0] rr;
    logic signed [11:0] o;
    dd = $signed({d[10], d});
    rr = $signed({3'b000, r});
    if (dd > rr)       o = dd - rr;
    else if (dd < -rr) o = dd + rr;
    else               o = '0;
    if (o > FULL_SCALE)  o = FULL_SCALE;
    if (o < -FULL_SCALE) o = -FULL_SCALE;
    return o[9:0];
  endfunction

  assign b_ready   = !b_valid_r || out_ready;
  assign a_ready   = !a_valid_r || b_ready;
  assign q_pop     = q_valid && a_ready;
  assign a_move    = a_valid_r && b_ready;
  assign out_valid = b_valid_r;
  assign out_item  = b_item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) deadzone_r <= DEADZONE_RST;
    else if (cfg_we) deadzone_r <= cfg_wdata;
  end

  // Stage A: dead zone and saturation
  assign a_valid_nxt = q_pop ? 1'b1 : (a_move ? 1'b0 : a_valid_r);

  always_ff @(posedge clk) begin
    if (q_pop) begin
      a_tick_r <= q_cmd.is_tick;
      a_wr_r   <= q_cmd.duty_write;
      a_sx_r   <= shape(q_cmd.dx, deadzone_r);
      a_sy_r   <= shape(q_cmd.dy, deadzone_r);
      a_ll_r   <= q_cmd.lamp_left;
      a_lr_r   <= q_cmd.lamp_right;
    end
  end

  // Stage B: duty scaling
  assign mag_y   = a_sy_r[9] ? 9'(-a_sy_r) : a_sy_r[8:0];
  assign mul_y   = {mag_y, 8'd0} + {8'd0, mag_y};
  assign m_wide  = STEER_CENTER + $signed({{2{a_sx_r[9]}}, a_sx_r});
  assign m_steer = m_wide[10:0];
  assign mul_s   = {22'd0, m_steer} * {11'd0, STEER_MUL};

  always_comb begin
    b_item_nxt.duty_write   = a_wr_r;
    b_item_nxt.lamp_left    = a_ll_r;
    b_item_nxt.lamp_right   = a_lr_r;
    b_item_nxt.duty_forward = '0;
    b_item_nxt.duty_reverse = '0;
    b_item_nxt.duty_steer   = '0;
    if (!a_tick_r) begin
      if (a_sy_r[9]) b_item_nxt.duty_reverse = mul_y[16:1];
      else           b_item_nxt.duty_forward = mul_y[16:1];
      b_item_nxt.duty_steer = mul_s[STEER_SHIFT +: 13];
    end
  end

  assign b_valid_nxt = a_move ? 1'b1 : (out_ready ? 1'b0 : b_valid_r);

  always_ff @(posedge clk) begin
    if (a_move) b_item_r <= b_item_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
    end else begin
      a_valid_r <= a_valid_nxt;
      b_valid_r <= b_valid_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_idle_tick_zero: assert property (@(posedge clk) disable iff (!rst_n)
    b_valid_r && !b_item_r.duty_write |->
    b_item_r.duty_forward == 16'd0 && b_item_r.duty_reverse == 16'd0 &&
    b_item_r.duty_steer == 13'd0)
    else $error("tick with link up carries a nonzero duty");
  a_one_direction: assert property (@(posedge clk) disable iff (!rst_n)
    b_valid_r |-> b_item_r.duty_forward == 16'd0 || b_item_r.duty_reverse == 16'd0)
    else $error("both bridge channels driven");
  a_clamped: assert property (@(posedge clk) disable iff (!rst_n)
    a_valid_r |-> a_sx_r <= 10'sd510 && a_sx_r >= -10'sd510)
    else $error("steer value not clamped");
`endif

endmodule
`default_nettype wire

// ===== tb/sv/stick_to_motor_pwm_and_lights_unit_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the stick-to-motor PWM and lamp unit.
module stick_to_motor_pwm_and_lights_unit_tb;
  import smpl_pkg::*;

  // Longest stretch without any transaction before the run is declared hung.
  // The receiver hold below is the longest legal quiet stretch by far.
  localparam int IDLE_LIMIT   = 4000;
  localparam int HOLD_CYCLES  = 300;
  // Wait past the result latency before touching config.
  localparam int PIPE_CYCLES  = 4;
  localparam int REPORT_LIMIT = 10;

  // Button masks for building reports: {triangle, cross, square, circle, start}
  localparam logic [4:0] BTN_NONE     = 5'b00000;
  localparam logic [4:0] BTN_TRIANGLE = 5'b10000;
  localparam logic [4:0] BTN_CROSS    = 5'b01000;
  localparam logic [4:0] BTN_SQUARE   = 5'b00100;
  localparam logic [4:0] BTN_CIRCLE   = 5'b00010;
  localparam logic [4:0] BTN_START    = 5'b00001;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_item_t  in_item   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_item;
  logic      cfg_we    = 1'b0;
  logic [8:0] cfg_wdata = '0;

  stick_to_motor_pwm_and_lights_unit u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Shadow copy of the unit's state. These mirror the reset values and are
  // advanced once per accepted input transaction, in acceptance order.
  // ---------------------------------------------------------------------------
  logic [8:0]         dz_radius   = DEADZONE_RST;
  logic signed [10:0] cal_x       = '0;
  logic signed [10:0] cal_y       = '0;
  logic               beam_on     = 1'b0;
  logic               turn_left   = 1'b0;
  logic               turn_right  = 1'b0;
  logic               flash_phase = 1'b0;

  // Duty and lamp words still owed by the unit, oldest first
  out_item_t duty_lamp_q[$];
  out_item_t owed;

  int sent_count    = 0;
  int checked_count = 0;
  int fail_count    = 0;
  int quiet_cycles  = 0;
  int in_idle_pct   = 0;
  int out_stall_pct = 0;
  int hold_arm      = 0;
  int hold_left     = 0;

  // Map a raw stick byte onto +-510 full scale.
  function automatic int axis_level(input logic signed [7:0] s);
    return 4 * (int'(s) + 128) - 510;
  endfunction

  // Dead zone first, then saturate; the difference can reach +-1020.
  function automatic int shape_axis(input int d);
    int r;
    int o;
    r = int'(dz_radius);
    if (d > r) o = d - r;
    else if (d < -r) o = d + r;
    else o = 0;
    if (o > 510) o = 510;
    if (o < -510) o = -510;
    return o;
  endfunction

  function automatic logic [1:0] lamp_color(input logic blink);
    if (blink && flash_phase) return LAMP_AMBER;
    return beam_on ? LAMP_WHITE : LAMP_OFF;
  endfunction

  // Advance the shadow state by one transaction and return the word it yields.
  function automatic out_item_t compute_duties_and_lamps(input in_item_t it);
    out_item_t r;
    int vx;
    int vy;
    int sx;
    int sy;
    r = '0;
    if (it.operation == OP_REPORT) begin
      vx = axis_level(it.stick_x);
      vy = axis_level(it.stick_y);
      // Select captures the raw levels before they are used below
      if (it.press_select) begin
        cal_x = 11'(vx);
        cal_y = 11'(vy);
      end
      // Only the highest-priority pressed button acts
      if (it.press_triangle) begin
        beam_on    = 1'b1;
        turn_left  = 1'b0;
        turn_right = 1'b0;
      end else if (it.press_cross) begin
        beam_on    = 1'b0;
        turn_left  = 1'b0;
        turn_right = 1'b0;
      end else if (it.press_square) begin
        flash_phase = 1'b1;
        turn_right  = 1'b0;
        turn_left   = ~turn_left;
      end else if (it.press_circle) begin
        flash_phase = 1'b1;
        turn_left   = 1'b0;
        turn_right  = ~turn_right;
      end else if (it.press_start) begin
        flash_phase = 1'b1;
        turn_left   = ~turn_left;
        turn_right  = ~turn_right;
      end
      sx = shape_axis(vx - int'(cal_x));
      sy = shape_axis(vy - int'(cal_y));
      r.duty_write   = 1'b1;
      r.duty_forward = (sy > 0) ? 16'(sy * 257 / 2) : 16'd0;
      r.duty_reverse = (sy < 0) ? 16'((-sy) * 257 / 2) : 16'd0;
      r.duty_steer   = 13'((1530 + sx) * 257 / 80);
    end else begin
      // Tick: duties stay zero; only a lost link asks for them to be applied
      r.duty_write = ~it.link_up;
    end
    r.lamp_left  = lamp_color(turn_left);
    r.lamp_right = lamp_color(turn_right);
    // The lamps show the phase before the tick flips it
    if (it.operation == OP_TICK) flash_phase = ~flash_phase;
    return r;
  endfunction

  function automatic in_item_t make_report(input int x, input int y, input logic sel,
                                           input logic [4:0] btn, input logic link);
    in_item_t it;
    it = '0;
    it.operation      = OP_REPORT;
    it.stick_x        = 8'(x);
    it.stick_y        = 8'(y);
    it.press_select   = sel;
    it.press_triangle = btn[4];
    it.press_cross    = btn[3];
    it.press_square   = btn[2];
    it.press_circle   = btn[1];
    it.press_start    = btn[0];
    it.link_up        = link;
    return it;
  endfunction

  function automatic in_item_t make_tick(input logic link);
    in_item_t it;
    it = '0;
    it.operation = OP_TICK;
    it.link_up   = link;
    return it;
  endfunction

  // Stick byte: anywhere, close to the calibrated center, or at the rails.
  function automatic logic signed [7:0] random_stick(input int cal);
    int s;
    case ($urandom_range(2))
      0: s = int'($urandom_range(255)) - 128;
      1: s = (cal - 2) / 4 + int'($urandom_range(40)) - 20;
      default: s = ($urandom_range(1) != 0) ? 127 - int'($urandom_range(1))
                                           : -128 + int'($urandom_range(1));
    endcase
    if (s > 127) s = 127;
    if (s < -128) s = -128;
    return 8'(s);
  endfunction

  function automatic in_item_t random_item();
    in_item_t it;
    it = '0;
    it.operation      = ($urandom_range(99) < 15) ? OP_TICK : OP_REPORT;
    it.stick_x        = random_stick(int'(cal_x));
    it.stick_y        = random_stick(int'(cal_y));
    it.press_select   = ($urandom_range(99) < 8);
    it.press_triangle = ($urandom_range(99) < 10);
    it.press_cross    = ($urandom_range(99) < 10);
    it.press_square   = ($urandom_range(99) < 12);
    it.press_circle   = ($urandom_range(99) < 12);
    it.press_start    = ($urandom_range(99) < 12);
    it.link_up        = ($urandom_range(99) < 75);
    return it;
  endfunction

  // ---------------------------------------------------------------------------
  // Sender: optionally idle, then raise valid and hold it until the unit takes
  // the transaction. Valid is left high so a following call keeps streaming;
  // it only drops in an idle cycle or when draining.
  // ---------------------------------------------------------------------------
  task automatic send_transaction(input in_item_t it);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (!in_ready);
    duty_lamp_q.push_back(compute_duties_and_lamps(it));
    sent_count++;
  endtask

  // Drop valid and wait until every owed word has come out, plus the latency.
  task automatic settle_pipeline();
    in_valid <= 1'b0;
    while (duty_lamp_q.size() != 0) @(posedge clk);
    repeat (PIPE_CYCLES) @(posedge clk);
  endtask

  // Write the dead zone only while the unit is empty.
  task automatic set_deadzone(input logic [8:0] value);
    settle_pipeline();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    dz_radius  = value;
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Rails, calibration, every button and its priority, both tick flavors.
  task automatic test_directed_cases();
    in_idle_pct   = 0;
    out_stall_pct = 0;
    send_transaction(make_report(0, 0, 1'b0, BTN_NONE, 1'b0));       // inside dead zone
    send_transaction(make_report(-128, -128, 1'b0, BTN_NONE, 1'b0)); // full reverse, left
    send_transaction(make_report(127, 127, 1'b0, BTN_NONE, 1'b0));   // full forward, right
    // Calibrate at opposite rails, then swing to the other rails: +-1020 saturates
    send_transaction(make_report(-128, 127, 1'b1, BTN_NONE, 1'b0));
    send_transaction(make_report(127, -128, 1'b0, BTN_NONE, 1'b0));
    send_transaction(make_report(0, 0, 1'b1, BTN_NONE, 1'b0));       // recenter
    send_transaction(make_report(1, -1, 1'b0, BTN_TRIANGLE, 1'b0));
    send_transaction(make_report(0, 0, 1'b0, 5'b11111, 1'b0));       // triangle wins
    send_transaction(make_report(0, 0, 1'b0, BTN_CROSS | BTN_SQUARE, 1'b0));
    send_transaction(make_report(0, 0, 1'b0, BTN_SQUARE | BTN_CIRCLE | BTN_START, 1'b0));
    send_transaction(make_tick(1'b1));
    send_transaction(make_tick(1'b0));
    send_transaction(make_report(20, 30, 1'b0, BTN_CIRCLE | BTN_START, 1'b0));
    send_transaction(make_report(-20, -30, 1'b0, BTN_START, 1'b0));
    send_transaction(make_tick(1'b1));
    send_transaction(make_report(64, -64, 1'b0, BTN_START, 1'b1));   // link ignored
    // A tick ignores the sticks and every button, select included
    send_transaction(make_report(0, 0, 1'b0, BTN_NONE, 1'b0) ^ '0);
    send_transaction('{operation: OP_TICK, stick_x: 8'sh7f, stick_y: -8'sd128,
                       press_select: 1'b1, press_triangle: 1'b1, press_cross: 1'b1,
                       press_square: 1'b1, press_circle: 1'b1, press_start: 1'b1,
                       link_up: 1'b1});
    send_transaction('{operation: OP_TICK, stick_x: -8'sd128, stick_y: 8'sh7f,
                       press_select: 1'b0, press_triangle: 1'b0, press_cross: 1'b0,
                       press_square: 1'b1, press_circle: 1'b0, press_start: 1'b1,
                       link_up: 1'b0});
    send_transaction(make_report(100, -100, 1'b0, BTN_CROSS, 1'b1));
    send_transaction(make_tick(1'b1));
    send_transaction(make_tick(1'b0));
  endtask

  // Walk the dead zone through its extremes, including wider than full scale.
  task automatic test_deadzone_extremes();
    logic [8:0] dz_list[7];
    dz_list = '{9'd0, 9'd511, 9'd510, 9'd1, 9'd256, 9'd255, DEADZONE_RST};
    in_idle_pct   = 0;
    out_stall_pct = 0;
    foreach (dz_list[i]) begin
      set_deadzone(dz_list[i]);
      repeat (20) send_transaction(random_item());
    end
  endtask

  // Bulk random traffic under four idle/stall mixes, new dead zone each phase.
  task automatic test_random_traffic();
    int idle_mix[4];
    int stall_mix[4];
    idle_mix  = '{0, 58, 0, 22};
    stall_mix = '{0, 0, 58, 22};
    foreach (idle_mix[p]) begin
      set_deadzone(9'($urandom_range(120)));
      in_idle_pct   = idle_mix[p];
      out_stall_pct = stall_mix[p];
      repeat (300) send_transaction(random_item());
    end
  endtask

  // Hold off the receiver while the sender keeps offering: the queue fills and
  // in_ready must drop without losing or reordering anything.
  task automatic test_receiver_hold();
    settle_pipeline();
    in_idle_pct   = 0;
    out_stall_pct = 0;
    hold_arm      = HOLD_CYCLES;
    repeat (30) send_transaction(random_item());
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: random stalls, plus a long hold counted here when armed.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (hold_arm != 0) begin
      hold_left = hold_arm;
      hold_arm  = 0;
    end
    if (hold_left != 0) begin
      hold_left = hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= out_stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Checker: compare every result transaction against the oldest owed word.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      checked_count++;
      if (duty_lamp_q.size() == 0) begin
        fail_count++;
        if (fail_count <= REPORT_LIMIT)
          $display("unexpected result: wr=%0d fwd=%0d rev=%0d steer=%0d L=%0d R=%0d",
                   out_item.duty_write, out_item.duty_forward, out_item.duty_reverse,
                   out_item.duty_steer, out_item.lamp_left, out_item.lamp_right);
      end else begin
        owed = duty_lamp_q.pop_front();
        if (out_item.duty_write   !== owed.duty_write   ||
            out_item.duty_forward !== owed.duty_forward ||
            out_item.duty_reverse !== owed.duty_reverse ||
            out_item.duty_steer   !== owed.duty_steer   ||
            out_item.lamp_left    !== owed.lamp_left    ||
            out_item.lamp_right   !== owed.lamp_right) begin
          fail_count++;
          if (fail_count <= REPORT_LIMIT) begin
            $display("mismatch at result %0d: exp wr=%0d fwd=%0d rev=%0d steer=%0d L=%0d R=%0d",
                     checked_count, owed.duty_write, owed.duty_forward, owed.duty_reverse,
                     owed.duty_steer, owed.lamp_left, owed.lamp_right);
            $display("                      got wr=%0d fwd=%0d rev=%0d steer=%0d L=%0d R=%0d",
                     out_item.duty_write, out_item.duty_forward, out_item.duty_reverse,
                     out_item.duty_steer, out_item.lamp_left, out_item.lamp_right);
          end
        end
      end
    end
  end

  // Watchdog: end the run if no transaction moves on either channel too long.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("timeout: no transaction for %0d cycles, %0d results owed",
               IDLE_LIMIT, duty_lamp_q.size());
      $display("Some tests failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence: reset once, run each test, drain, report.
  // ---------------------------------------------------------------------------
  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_cases();
    test_deadzone_extremes();
    test_random_traffic();
    test_receiver_hold();
    settle_pipeline();
    repeat (PIPE_CYCLES) @(posedge clk);
    if (duty_lamp_q.size() != 0) begin
      fail_count += duty_lamp_q.size();
      $display("%0d results never arrived", duty_lamp_q.size());
    end
    $display("Run: %0d transactions in, %0d results checked, %0d failures.",
             sent_count, checked_count, fail_count);
    $display("Covered dead zones 0..511, all buttons and ticks, stalls and a long hold.");
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/smpl_pkg.sv
rtl/core/smpl_front.sv
rtl/core/smpl_queue.sv
rtl/core/smpl_back.sv
rtl/core/stick_to_motor_pwm_and_lights_unit.sv
tb/sv/stick_to_motor_pwm_and_lights_unit_tb.sv
